@@ rtl/swc_pkg.sv @@
// Package for the single-peak window checker.
// Holds sizes, register indexes, phase and outcome codes, and the shared structs.
// No dependencies.
package swc_pkg;

	localparam int MAX_LANES = 2;
	localparam int MAX_SEQ   = 64;

	localparam int TIME_W    = $clog2(MAX_SEQ);
	localparam int LEN_W     = $clog2(MAX_SEQ + 1);
	localparam int LANE_W    = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
	localparam int LANES_W   = $clog2(MAX_LANES + 1);

	localparam int SCORE_W   = 16;
	localparam int SEQ_REG_W = 7;
	localparam int LANE_REG_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int OUTCOME_W  = 3;
	localparam int PHASE_W    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEQ_LEN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LANES     = 2'd2;

	localparam logic [SCORE_W-1:0]    THRESHOLD_RST = 16'd32113;
	localparam logic [SEQ_REG_W-1:0]  SEQ_LEN_RST   = 7'd64;
	localparam logic [LANE_REG_W-1:0] LANES_RST     = 2'd2;

	localparam logic [PHASE_W-1:0] PH_WAIT = 2'd0;
	localparam logic [PHASE_W-1:0] PH_IN   = 2'd1;
	localparam logic [PHASE_W-1:0] PH_DONE = 2'd2;

	localparam logic [OUTCOME_W-1:0] OC_OK          = 3'd0;
	localparam logic [OUTCOME_W-1:0] OC_STARTS_HIGH = 3'd1;
	localparam logic [OUTCOME_W-1:0] OC_INCOMPLETE  = 3'd2;
	localparam logic [OUTCOME_W-1:0] OC_SECOND      = 3'd3;
	localparam logic [OUTCOME_W-1:0] OC_NO_OVERLAP  = 3'd4;

	typedef struct packed {
		logic [SCORE_W-1:0] threshold;
		logic [LEN_W-1:0]   len;
		logic [LANES_W-1:0] lanes;
	} cfg_t;

	typedef struct packed {
		logic                 valid;
		logic                 detected;
		logic [OUTCOME_W-1:0] outcome;
	} res_t;

endpackage

@@ rtl/swc_cfg.sv @@
// Configuration registers of the single-peak window checker.
// Stores threshold, sequence length and lane count, and clamps sequence length and lane count to the legal range.
// Depends on swc_pkg.
module swc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [swc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [swc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output swc_pkg::cfg_t                   cfg
);

	logic [swc_pkg::SCORE_W-1:0]    threshold_q;
	logic [swc_pkg::SEQ_REG_W-1:0]  seq_len_q;
	logic [swc_pkg::LANE_REG_W-1:0] lanes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= swc_pkg::THRESHOLD_RST;
			seq_len_q   <= swc_pkg::SEQ_LEN_RST;
			lanes_q     <= swc_pkg::LANES_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				swc_pkg::REG_THRESHOLD: threshold_q <= cfg_data[swc_pkg::SCORE_W-1:0];
				swc_pkg::REG_SEQ_LEN:   seq_len_q   <= cfg_data[swc_pkg::SEQ_REG_W-1:0];
				swc_pkg::REG_LANES:     lanes_q     <= cfg_data[swc_pkg::LANE_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.threshold = threshold_q;
		if (32'(seq_len_q) < 32'd2) begin
			cfg.len = swc_pkg::LEN_W'(2);
		end else if (32'(seq_len_q) > 32'(swc_pkg::MAX_SEQ)) begin
			cfg.len = swc_pkg::LEN_W'(swc_pkg::MAX_SEQ);
		end else begin
			cfg.len = swc_pkg::LEN_W'(seq_len_q);
		end
		if (32'(lanes_q) < 32'd1) begin
			cfg.lanes = swc_pkg::LANES_W'(1);
		end else if (32'(lanes_q) > 32'(swc_pkg::MAX_LANES)) begin
			cfg.lanes = swc_pkg::LANES_W'(swc_pkg::MAX_LANES);
		end else begin
			cfg.lanes = swc_pkg::LANES_W'(lanes_q);
		end
	end

endmodule

@@ rtl/swc_core.sv @@
// Window state of the single-peak window checker: per-lane peak tracking,
// the store of finished peaks, the overlap check and the verdict. Depends on swc_pkg.
module swc_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  swc_pkg::cfg_t                 cfg,
	input  logic                          step,
	input  logic [swc_pkg::SCORE_W-1:0]   score,
	output swc_pkg::res_t                 res
);

	logic [swc_pkg::TIME_W-1:0]    time_q, time_n;
	logic [swc_pkg::LANE_W-1:0]    lane_q, lane_n;
	logic [swc_pkg::PHASE_W-1:0]   phase_q, phase_n;
	logic [swc_pkg::TIME_W-1:0]    pstart_q, pstart_n;
	logic [swc_pkg::TIME_W-1:0]    pend_q, pend_n;
	logic                          overlap_q, overlap_n;
	logic [swc_pkg::OUTCOME_W-1:0] fail_q, fail_n;

	logic [swc_pkg::TIME_W-1:0] store_start_q [swc_pkg::MAX_LANES];
	logic [swc_pkg::TIME_W-1:0] store_end_q   [swc_pkg::MAX_LANES];

	logic high, above, last_step, last_lane, store_we;
	logic [swc_pkg::TIME_W-1:0] pstart_t, pend_t;
	logic [swc_pkg::PHASE_W-1:0] phase_t;

	assign high      = score >= cfg.threshold;
	assign above     = score > cfg.threshold;
	assign last_step = (swc_pkg::LEN_W'(time_q) + swc_pkg::LEN_W'(1)) >= cfg.len;
	assign last_lane = (swc_pkg::LANES_W'(lane_q) + swc_pkg::LANES_W'(1)) >= cfg.lanes;

	always_comb begin
		pstart_t  = pstart_q;
		pend_t    = pend_q;
		phase_t   = phase_q;
		fail_n    = fail_q;
		overlap_n = overlap_q;
		store_we  = 1'b0;
		if (fail_q == swc_pkg::OC_OK) begin
			if (time_q == '0) begin
				if (above) begin
					fail_n = swc_pkg::OC_STARTS_HIGH;
				end
			end else begin
				case (phase_q)
					swc_pkg::PH_WAIT: begin
						if (high) begin
							pstart_t = time_q;
							phase_t  = swc_pkg::PH_IN;
						end
					end
					swc_pkg::PH_IN: begin
						if (!high) begin
							pend_t  = time_q - swc_pkg::TIME_W'(1);
							phase_t = swc_pkg::PH_DONE;
						end
					end
					default: begin
						if (high) begin
							fail_n = swc_pkg::OC_SECOND;
						end
					end
				endcase
			end
			if (fail_n == swc_pkg::OC_OK && last_step) begin
				if (phase_t != swc_pkg::PH_DONE) begin
					fail_n = swc_pkg::OC_INCOMPLETE;
				end else begin
					store_we = 1'b1;
					for (int k = 0; k < swc_pkg::MAX_LANES; k++) begin
						if (swc_pkg::LANE_W'(k) < lane_q && pstart_t <= store_end_q[k] &&
								store_start_q[k] <= pend_t) begin
							overlap_n = 1'b1;
						end
					end
				end
			end
		end

		time_n   = time_q + swc_pkg::TIME_W'(1);
		lane_n   = lane_q;
		phase_n  = phase_t;
		pstart_n = pstart_t;
		pend_n   = pend_t;
		res.valid    = 1'b0;
		res.detected = 1'b0;
		res.outcome  = swc_pkg::OC_OK;
		if (last_step) begin
			time_n   = '0;
			phase_n  = swc_pkg::PH_WAIT;
			pstart_n = '0;
			pend_n   = '0;
			if (!last_lane) begin
				lane_n = lane_q + swc_pkg::LANE_W'(1);
			end else begin
				lane_n    = '0;
				res.valid = 1'b1;
				if (fail_n != swc_pkg::OC_OK) begin
					res.outcome = fail_n;
				end else if (cfg.lanes < swc_pkg::LANES_W'(2) || overlap_n) begin
					res.detected = 1'b1;
				end else begin
					res.outcome = swc_pkg::OC_NO_OVERLAP;
				end
				fail_n    = swc_pkg::OC_OK;
				overlap_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q    <= '0;
			lane_q    <= '0;
			phase_q   <= swc_pkg::PH_WAIT;
			pstart_q  <= '0;
			pend_q    <= '0;
			overlap_q <= 1'b0;
			fail_q    <= swc_pkg::OC_OK;
		end else if (step) begin
			time_q    <= time_n;
			lane_q    <= lane_n;
			phase_q   <= phase_n;
			pstart_q  <= pstart_n;
			pend_q    <= pend_n;
			overlap_q <= overlap_n;
			fail_q    <= fail_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step && store_we) begin
			store_start_q[lane_q] <= pstart_t;
			store_end_q[lane_q]   <= pend_t;
		end
	end

endmodule

@@ rtl/single_peak_window_checker.sv @@
// Single-peak window checker: input register, window logic and result register.
// Scores of one window come in lane by lane; one verdict leaves at the window's end.
// Depends on swc_pkg, swc_cfg and swc_core.
//
// Usage: scores enter on score/score_valid/score_ready, one item per time step,
// all steps of lane 0 first, then lane 1. Nothing comes out until the last item
// of a window; that item produces one result on detected/outcome with
// result_valid/result_ready. Registers are written through cfg_write, cfg_index
// and cfg_data; the user does so only while no window is in progress, which
// the block does not enforce. Throughput is one item per cycle while score_ready
// is high: an accepted item sits in the input register while the window logic
// evaluates it; the window's final item sets result_valid as it leaves that
// register. The result register lets the next item in while a verdict waits;
// only when a verdict is still held and the item in the input register would
// produce another does score_ready drop.
// After reset the window is empty, the registers hold their defaults
// (threshold 32113, 64 steps, 2 lanes), and no result is pending.
module single_peak_window_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [swc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           score_valid,
	output logic                           score_ready,
	input  logic [swc_pkg::SCORE_W-1:0]    score,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic                           detected,
	output logic [swc_pkg::OUTCOME_W-1:0]  outcome
);

	swc_pkg::cfg_t cfg;
	swc_pkg::res_t res;

	logic                          valid_s1;
	logic [swc_pkg::SCORE_W-1:0]   score_s1;
	logic                          result_valid_q;
	logic                          detected_q;
	logic [swc_pkg::OUTCOME_W-1:0] outcome_q;
	logic                          advance, step;

	swc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	swc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (step),
		.score  (score_s1),
		.res    (res)
	);

	assign advance     = !res.valid || !result_valid_q || result_ready;
	assign step        = valid_s1 && advance;
	assign score_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (score_ready) begin
			valid_s1 <= score_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (score_valid && score_ready) begin
			score_s1 <= score;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (step && res.valid) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			detected_q <= res.detected;
			outcome_q  <= res.outcome;
		end
	end

	assign result_valid = result_valid_q;
	assign detected     = detected_q;
	assign outcome      = outcome_q;

	a_detected_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && detected_q |-> outcome_q == swc_pkg::OC_OK)
		else $error("detected verdict carries a failure code");

	a_outcome_known: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> outcome_q <= swc_pkg::OC_NO_OVERLAP)
		else $error("verdict outcome code out of range");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(score_s1))
		else $error("stalled item lost from the input register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_ready |-> !(step && res.valid))
		else $error("pending verdict overwritten");

endmodule
